@@ src/dense_graph_shortest_path_defines.svh @@
// Assertion macros used by the checker file.
`ifndef DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH
`define DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH

// Clocked assertion with reset disable; expects clk and arst_n in scope.
`define DGSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the macro above.
`define DGSP_ASSERT_IMP(lbl, pre, post, msg) \
	`DGSP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

@@ src/dgsp_pkg.sv @@
`default_nettype none
package dgsp_pkg;
	localparam int DIST_BITS = 27;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_RUN    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic                 settled;
		logic                 reached;
		logic [DIST_BITS-1:0] dist_val;
	} vertex_entry_t;
endpackage
`default_nettype wire

@@ src/dgsp_ram.sv @@
`default_nettype none
module dgsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/dense_graph_shortest_path.sv @@
// Shortest paths from one source over an undirected weighted edge matrix.
// Requests arrive on req_valid/req_stall with command, vertex_a, vertex_b,
// edge_weight and edge_present; one result per request leaves on
// res_valid/res_stall with distance, reachable and settled_count.
// The user writes vertex_count via vertex_count_we/vertex_count_wdata only while
// idle; the block does not enforce this. After reset the edge memory is swept
// to no-edge, one entry per cycle, over all 2^(2*ceil(log2(MAX_VERTICES)))
// entries (1048576 at the default); req_stall is high during the sweep. An
// edge write stores entry (a,b) on acceptance and (b,a) in ST_EW2, then ST_FIN
// loads the result register; a distance read reads the vertex memory in ST_RD,
// then passes to ST_FIN. A run first clears the flags of all MAX_VERTICES
// vertex entries, then for each settled vertex makes one scan of the vertex
// memory to select and one pass over the matrix row to relax, each reading one
// entry per cycle. One request is in work at a time. A finished result waits
// in the output register while res_stall is high; the next request is taken
// meanwhile, and its result waits until the register is free.
`default_nettype none
module dense_graph_shortest_path #(
	parameter int MAX_VERTICES = 1024,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vertex_count_we,
	input  wire logic [10:0]                    vertex_count_wdata,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [1:0]                     command,
	input  wire logic [9:0]                     vertex_a,
	input  wire logic [9:0]                     vertex_b,
	input  wire logic [15:0]                    edge_weight,
	input  wire logic                           edge_present,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic [dgsp_pkg::DIST_BITS-1:0]      distance,
	output logic                                reachable,
	output logic [10:0]                         settled_count
);
	import dgsp_pkg::*;

	localparam int VB  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int XW  = (CW > 11) ? CW : 11;
	localparam int EW  = WEIGHT_BITS + 1;
	localparam int EAW = 2 * VB;
	localparam int SW  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_EW2    = 4'd2;
	localparam logic [3:0] ST_RD     = 4'd3;
	localparam logic [3:0] ST_RCLR   = 4'd4;
	localparam logic [3:0] ST_RINIT  = 4'd5;
	localparam logic [3:0] ST_SEL    = 4'd6;
	localparam logic [3:0] ST_SETTLE = 4'd7;
	localparam logic [3:0] ST_REL    = 4'd8;
	localparam logic [3:0] ST_FIN    = 4'd9;

	logic [3:0]           state_q;
	logic [EAW-1:0]       clr_q;
	logic [XW-1:0]        vertex_count_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        settled_q;
	logic                 p_s1;
	logic [VB-1:0]        jj_s1;
	logic                 found_q;
	logic [VB-1:0]        best_q;
	logic [DIST_BITS-1:0] best_d_q;
	logic [VB-1:0]        src_q;
	logic                 src_ok_q;
	logic [VB-1:0]        ea_q;
	logic [VB-1:0]        eb_q;
	logic [EW-1:0]        e_data_q;
	logic [DIST_BITS-1:0] pend_dist_q;
	logic                 pend_reach_q;
	logic [10:0]          pend_cnt_q;
	logic                 res_valid_q;
	logic [DIST_BITS-1:0] distance_q;
	logic                 reachable_q;
	logic [10:0]          settled_count_q;

	logic [XW-1:0]          cnt_x;
	logic [CW-1:0]          cnt;
	logic                   a_ok;
	logic                   b_ok;
	logic [VB+9:0]          a_wide;
	logic [VB+9:0]          b_wide;
	logic [VB-1:0]          a_idx;
	logic [VB-1:0]          b_idx;
	logic [WEIGHT_BITS+15:0] w_wide;
	logic [WEIGHT_BITS-1:0] w_in;
	logic [VB-1:0]          j_idx;
	logic [CW+10:0]         sc_wide;
	logic                   accept;

	logic                 e_we;
	logic [EAW-1:0]       e_waddr;
	logic [EW-1:0]        e_wdata;
	logic [EAW-1:0]       e_raddr;
	logic [EW-1:0]        e_rdata;
	logic                 v_we;
	logic [VB-1:0]        v_waddr;
	vertex_entry_t        v_wdata;
	logic [VB-1:0]        v_raddr;
	vertex_entry_t        v_rdata;

	logic [SW-1:0]        sum;
	logic [DIST_BITS-1:0] cand;
	logic                 upd;
	logic                 better;

	assign cnt_x = (vertex_count_q == '0) ? XW'(1) :
		(vertex_count_q > XW'(MAX_VERTICES)) ? XW'(MAX_VERTICES) : vertex_count_q;
	assign cnt     = cnt_x[CW-1:0];
	assign a_ok    = XW'(vertex_a) < cnt_x;
	assign b_ok    = XW'(vertex_b) < cnt_x;
	assign a_wide  = {{VB{1'b0}}, vertex_a};
	assign b_wide  = {{VB{1'b0}}, vertex_b};
	assign a_idx   = a_wide[VB-1:0];
	assign b_idx   = b_wide[VB-1:0];
	assign w_wide  = {{WEIGHT_BITS{1'b0}}, edge_weight};
	assign w_in    = w_wide[WEIGHT_BITS-1:0];
	assign j_idx   = j_q[VB-1:0];
	assign sc_wide = {11'd0, settled_q};

	assign req_stall     = state_q != ST_IDLE;
	assign accept        = req_valid && !req_stall;
	assign res_valid     = res_valid_q;
	assign distance      = distance_q;
	assign reachable     = reachable_q;
	assign settled_count = settled_count_q;

	assign sum  = SW'(best_d_q) + SW'(e_rdata[WEIGHT_BITS-1:0]);
	assign cand = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
	assign upd  = e_rdata[EW-1] && !v_rdata.settled &&
		(!v_rdata.reached || cand < v_rdata.dist_val);
	assign better = !v_rdata.settled && v_rdata.reached &&
		(!found_q || v_rdata.dist_val < best_d_q);

	always_comb begin
		e_we    = 1'b0;
		e_waddr = {ea_q, eb_q};
		e_wdata = e_data_q;
		e_raddr = {best_q, j_idx};
		v_we    = 1'b0;
		v_waddr = j_idx;
		v_wdata = '0;
		v_raddr = j_idx;
		case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = clr_q;
				e_wdata = '0;
				v_we    = 1'b1;
				v_waddr = clr_q[VB-1:0];
			end
			ST_IDLE: begin
				v_raddr = a_idx;
				if (accept && command == CMD_WRITE && a_ok && b_ok) begin
					e_we    = 1'b1;
					e_waddr = {a_idx, b_idx};
					e_wdata = {edge_present, edge_present ? w_in : {WEIGHT_BITS{1'b0}}};
				end
			end
			ST_EW2: begin
				e_we    = 1'b1;
				e_waddr = {eb_q, ea_q};
			end
			ST_RCLR: begin
				v_we = 1'b1;
			end
			ST_RINIT: begin
				v_we    = 1'b1;
				v_waddr = src_q;
				v_wdata = '{settled: 1'b0, reached: 1'b1, dist_val: '0};
			end
			ST_SETTLE: begin
				v_we    = found_q;
				v_waddr = best_q;
				v_wdata = '{settled: 1'b1, reached: 1'b1, dist_val: best_d_q};
			end
			ST_REL: begin
				v_we    = p_s1 && upd;
				v_waddr = jj_s1;
				v_wdata = '{settled: 1'b0, reached: 1'b1, dist_val: cand};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			vertex_count_q  <= XW'(MAX_VERTICES);
			j_q             <= '0;
			settled_q       <= '0;
			p_s1            <= 1'b0;
			jj_s1           <= '0;
			found_q         <= 1'b0;
			best_q          <= '0;
			best_d_q        <= '0;
			src_q           <= '0;
			src_ok_q        <= 1'b0;
			ea_q            <= '0;
			eb_q            <= '0;
			e_data_q        <= '0;
			pend_dist_q     <= '0;
			pend_reach_q    <= 1'b0;
			pend_cnt_q      <= '0;
			res_valid_q     <= 1'b0;
			distance_q      <= '0;
			reachable_q     <= 1'b0;
			settled_count_q <= '0;
		end else begin
			if (vertex_count_we) begin
				vertex_count_q <= XW'(vertex_count_wdata);
			end
			if (res_valid_q && !res_stall && state_q != ST_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						pend_dist_q  <= '0;
						pend_reach_q <= 1'b0;
						pend_cnt_q   <= '0;
						case (command)
							CMD_WRITE: begin
								ea_q     <= a_idx;
								eb_q     <= b_idx;
								e_data_q <= {edge_present,
									edge_present ? w_in : {WEIGHT_BITS{1'b0}}};
								state_q  <= (a_ok && b_ok) ? ST_EW2 : ST_FIN;
							end
							CMD_RUN: begin
								src_q    <= a_idx;
								src_ok_q <= a_ok;
								j_q      <= '0;
								state_q  <= ST_RCLR;
							end
							CMD_READ: begin
								state_q <= a_ok ? ST_RD : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_EW2: begin
					state_q <= ST_FIN;
				end
				ST_RD: begin
					pend_reach_q <= v_rdata.reached;
					pend_dist_q  <= v_rdata.reached ? v_rdata.dist_val : '0;
					state_q      <= ST_FIN;
				end
				ST_RCLR: begin
					if (j_q == CW'(MAX_VERTICES - 1)) begin
						j_q     <= '0;
						state_q <= src_ok_q ? ST_RINIT : ST_FIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RINIT: begin
					settled_q <= '0;
					found_q   <= 1'b0;
					p_s1      <= 1'b0;
					j_q       <= '0;
					state_q   <= ST_SEL;
				end
				ST_SEL: begin
					if (j_q < cnt) begin
						p_s1  <= 1'b1;
						jj_s1 <= j_idx;
						j_q   <= j_q + 1'b1;
					end else begin
						p_s1 <= 1'b0;
					end
					if (p_s1 && better) begin
						best_q   <= jj_s1;
						best_d_q <= v_rdata.dist_val;
						found_q  <= 1'b1;
					end
					if (j_q == cnt && !p_s1) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					if (found_q) begin
						settled_q <= settled_q + 1'b1;
						j_q       <= '0;
						p_s1      <= 1'b0;
						state_q   <= ST_REL;
					end else begin
						pend_cnt_q <= sc_wide[10:0];
						state_q    <= ST_FIN;
					end
				end
				ST_REL: begin
					if (j_q < cnt) begin
						p_s1  <= 1'b1;
						jj_s1 <= j_idx;
						j_q   <= j_q + 1'b1;
					end else begin
						p_s1 <= 1'b0;
					end
					if (j_q == cnt && !p_s1) begin
						found_q <= 1'b0;
						j_q     <= '0;
						state_q <= ST_SEL;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q     <= 1'b1;
						distance_q      <= pend_dist_q;
						reachable_q     <= pend_reach_q;
						settled_count_q <= pend_cnt_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dgsp_ram #(
		.WIDTH (EW),
		.DEPTH (1 << EAW)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	dgsp_ram #(
		.WIDTH ($bits(vertex_entry_t)),
		.DEPTH (1 << VB)
	) u_vertex_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);
endmodule
`default_nettype wire

@@ src/dgsp_checker.sv @@
`default_nettype none
`include "dense_graph_shortest_path_defines.svh"
module dgsp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_stall,
	input wire logic                      res_valid,
	input wire logic                      res_stall,
	input wire logic [dgsp_pkg::DIST_BITS-1:0] distance,
	input wire logic                      reachable,
	input wire logic [10:0]               settled_count
);
	import dgsp_pkg::*;

	`DGSP_ASSERT_IMP(a_res_hold, res_valid && res_stall, ##1 res_valid, "result dropped")
	`DGSP_ASSERT_IMP(a_busy_after_req, req_valid && !req_stall, ##1 req_stall, "not busy")
	`DGSP_ASSERT_IMP(a_reach_no_count, res_valid && reachable, settled_count == '0, "count on read")
	`DGSP_ASSERT_IMP(a_unreached_zero, res_valid && !reachable, distance == '0, "stray distance")
endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (.*);
`default_nettype wire
